[src/adp_pkg.sv]
// shared types, constants and codes for the allpass interpolated delay line
package adp_pkg;

    localparam int DEPTH      = 4096;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int SAMPLE_W   = 24;
    localparam int LAG_W      = 12;
    localparam int COEFF_W    = 17;
    localparam int GAIN_W     = 16;
    localparam int OP_W       = 2;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int GAIN_FRAC  = 12;
    localparam int COEFF_FRAC = 16;

    localparam int MUL_A_W = SAMPLE_W + 1;
    localparam int MUL_B_W = COEFF_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd0;
    localparam logic [OP_W-1:0] OP_TAP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_TAP_WRITE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_LAG      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLPASS_COEFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN    = 2'd2;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd4096;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic signed [SAMPLE_W-1:0] in_sample;
        logic [LAG_W-1:0]           tap_age;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic signed [SAMPLE_W-1:0] tap_value;
    } rsp_t;

    typedef struct packed {
        logic [LAG_W-1:0]          read_lag;
        logic signed [COEFF_W-1:0] allpass_coeff;
        logic signed [GAIN_W-1:0]  input_gain;
    } cfg_t;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GAIN,
        ST_STORE,
        ST_READ,
        ST_COEFF,
        ST_FINISH,
        ST_TAP_RD,
        ST_TAP_CAP,
        ST_TAP_WR,
        ST_DONE
    } state_t;

endpackage

[src/allpass_interpolated_delay_line.sv]
// top level: configuration registers, result register and unit wiring
// Fractional delay line with first-order allpass interpolation over a
// 4096-entry circular store of 24-bit samples.
// Request channel (req_valid, req_stall, req_word): one word per operation,
// op selects process sample, read tap or write tap. Result channel
// (rsp_valid, rsp_stall, rsp_word): exactly one word per request.
// A request is taken when req_valid is high and req_stall low; a result
// leaves when rsp_valid is high and rsp_stall low.
// A processed sample passes through the gain, store, read, coefficient and
// finish states before its result is loaded, a tap read through the read and
// capture states, a tap write through the write state; an unused op code goes
// straight to the result. One item is in flight at a time; the single
// multiplier serves the gain and then the allpass product.
// After reset the store is zeroed by a clearing pass, during which
// req_stall stays high; configuration writes are taken throughout.
// If rsp_stall holds a finished result, the next request may still be taken;
// its own result waits in the sequencer until the result register drains.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written only while idle; the block itself does not enforce this.
module allpass_interpolated_delay_line (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  adp_pkg::req_t                    req_word,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output adp_pkg::rsp_t                    rsp_word,
    input  logic                             cfg_we,
    input  logic [adp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adp_pkg::CFG_W-1:0]        cfg_data
);
    import adp_pkg::*;

    cfg_t                     cfg_reg, cfg_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_t                     rsp_word_reg, rsp_word_next;
    logic                     rsp_free;
    logic                     rsp_load;
    rsp_t                     res;
    mul_req_t                 mul_req;
    logic signed [PROD_W-1:0] prod;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [SAMPLE_W-1:0]      ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [SAMPLE_W-1:0]      ram_rdata;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_READ_LAG:      cfg_next.read_lag      = cfg_data[LAG_W-1:0];
                CFG_ALLPASS_COEFF: cfg_next.allpass_coeff = $signed(cfg_data[COEFF_W-1:0]);
                CFG_INPUT_GAIN:    cfg_next.input_gain    = $signed(cfg_data[GAIN_W-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next  = rsp_word_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_lag      <= '0;
            cfg_reg.allpass_coeff <= '0;
            cfg_reg.input_gain    <= GAIN_RESET;
            rsp_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    adp_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .cfg       (cfg_reg),
        .rsp_free  (rsp_free),
        .rsp_load  (rsp_load),
        .res       (res),
        .mul_req   (mul_req),
        .prod      (prod),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    adp_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    adp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[src/adp_ram.sv]
// generic single write port ram with registered read
module adp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/adp_mul.sv]
// shared signed multiplier with product register
module adp_mul (
    input  logic                              clk,
    input  adp_pkg::mul_req_t                 req,
    output logic signed [adp_pkg::PROD_W-1:0] prod
);
    import adp_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = prod_reg;
        if (req.en)
        begin
            prod_next = req.a * req.b;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

[src/adp_seq.sv]
// sequencer and datapath: clearing pass, gain, store access, allpass step
module adp_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  adp_pkg::req_t                     req_word,
    input  adp_pkg::cfg_t                     cfg,
    input  logic                              rsp_free,
    output logic                              rsp_load,
    output adp_pkg::rsp_t                     res,
    output adp_pkg::mul_req_t                 mul_req,
    input  logic signed [adp_pkg::PROD_W-1:0] prod,
    output logic                              ram_we,
    output logic [adp_pkg::ADDR_W-1:0]        ram_waddr,
    output logic [adp_pkg::SAMPLE_W-1:0]      ram_wdata,
    output logic [adp_pkg::ADDR_W-1:0]        ram_raddr,
    input  logic [adp_pkg::SAMPLE_W-1:0]      ram_rdata
);
    import adp_pkg::*;

    localparam int GSH_W = PROD_W - GAIN_FRAC;
    localparam int CSH_W = PROD_W - COEFF_FRAC;
    localparam int SUM_W = CSH_W + 1;
    localparam logic signed [PROD_W-1:0] GAIN_HALF  = PROD_W'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [PROD_W-1:0] COEFF_HALF = PROD_W'(1) <<< (COEFF_FRAC - 1);
    localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    function automatic logic signed [SAMPLE_W-1:0] sat_g(input logic signed [GSH_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > GSH_W'(SMAX))
        begin
            r = SMAX;
        end
        else if (v < GSH_W'(SMIN))
        begin
            r = SMIN;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_s(input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SUM_W'(SMAX))
        begin
            r = SMAX;
        end
        else if (v < SUM_W'(SMIN))
        begin
            r = SMIN;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    state_t                     state_reg, state_next;
    req_t                       req_reg, req_next;
    rsp_t                       res_reg, res_next;
    logic [ADDR_W-1:0]          wp_reg, wp_next;
    logic [ADDR_W-1:0]          clr_reg, clr_next;
    logic signed [SAMPLE_W-1:0] prev_out_reg, prev_out_next;
    logic signed [SAMPLE_W-1:0] prev_read_reg, prev_read_next;
    logic signed [SAMPLE_W-1:0] r_reg, r_next;

    logic signed [PROD_W-1:0]   gain_rnd;
    logic signed [PROD_W-1:0]   coeff_rnd;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] rd_s;
    logic [ADDR_W-1:0]          lag_addr;
    logic [ADDR_W-1:0]          tap_addr;

    assign rd_s      = $signed(ram_rdata);
    assign gain_rnd  = prod + GAIN_HALF;
    assign coeff_rnd = prod + COEFF_HALF;
    assign sum       = SUM_W'($signed(coeff_rnd[PROD_W-1:COEFF_FRAC])) + SUM_W'(prev_read_reg);
    assign y         = sat_s(sum);
    assign lag_addr  = wp_reg - ADDR_W'(cfg.read_lag);
    assign tap_addr  = wp_reg - ADDR_W'(1) - ADDR_W'(req_reg.tap_age);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_word.op)
                        OP_SAMPLE:    state_next = ST_GAIN;
                        OP_TAP_READ:  state_next = ST_TAP_RD;
                        OP_TAP_WRITE: state_next = ST_TAP_WR;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_GAIN:    state_next = ST_STORE;
            ST_STORE:   state_next = ST_READ;
            ST_READ:    state_next = ST_COEFF;
            ST_COEFF:   state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_DONE;
            ST_TAP_RD:  state_next = ST_TAP_CAP;
            ST_TAP_CAP: state_next = ST_DONE;
            ST_TAP_WR:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        req_next       = req_reg;
        res_next       = res_reg;
        wp_next        = wp_reg;
        clr_next       = clr_reg;
        prev_out_next  = prev_out_reg;
        prev_read_next = prev_read_reg;
        r_next         = r_reg;
        req_stall      = 1'b1;
        rsp_load       = 1'b0;
        mul_req        = '0;
        ram_we         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = '0;
        ram_raddr      = lag_addr;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    req_next = req_word;
                    res_next = '0;
                end
            end
            ST_GAIN:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(req_reg.in_sample);
                mul_req.b  = MUL_B_W'(cfg.input_gain);
            end
            ST_STORE:
            begin
                ram_we    = 1'b1;
                ram_wdata = sat_g($signed(gain_rnd[PROD_W-1:GAIN_FRAC]));
            end
            ST_READ:
            begin
                ram_raddr = lag_addr;
            end
            ST_COEFF:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(rd_s) - MUL_A_W'(prev_out_reg);
                mul_req.b  = cfg.allpass_coeff;
                r_next     = rd_s;
            end
            ST_FINISH:
            begin
                res_next.out_sample = y;
                prev_out_next       = y;
                prev_read_next      = r_reg;
                wp_next             = wp_reg + ADDR_W'(1);
            end
            ST_TAP_RD:
            begin
                ram_raddr = tap_addr;
            end
            ST_TAP_CAP:
            begin
                res_next.tap_value = rd_s;
            end
            ST_TAP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = tap_addr;
                ram_wdata = req_reg.in_sample;
            end
            ST_DONE:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            wp_reg        <= '0;
            clr_reg       <= '0;
            prev_out_reg  <= '0;
            prev_read_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            clr_reg       <= clr_next;
            prev_out_reg  <= prev_out_next;
            prev_read_reg <= prev_read_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        r_reg   <= r_next;
    end

    assign res = res_reg;

endmodule

[src/adp_checker.sv]
// port level checks for the allpass interpolated delay line
module adp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input adp_pkg::rsp_t rsp_word
);
    import adp_pkg::*;

    // held result word stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("result word changed while stalled");

    // one word at a time: busy right after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous word in flight");

    // a result carries at most one non-zero field
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.out_sample != '0) |-> rsp_word.tap_value == '0)
        else $error("both result fields non-zero");

    // a new result only comes out of a busy sequencer
    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result appeared without work in progress");

endmodule

bind allpass_interpolated_delay_line adp_checker u_adp_checker (.*);

[test/tb_allpass_interpolated_delay_line.sv]
// self-checking testbench for the allpass interpolated delay line
`timescale 1ns / 1ps

module tb;
    import adp_pkg::*;

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_word = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp_word;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // mirror of the line state and registers
    logic signed [SAMPLE_W-1:0] line_mem [DEPTH];
    logic [ADDR_W-1:0] wr_ptr = '0;
    logic signed [SAMPLE_W-1:0] last_out = '0;
    logic signed [SAMPLE_W-1:0] last_read = '0;
    logic [LAG_W-1:0] lag_reg = '0;
    logic signed [COEFF_W-1:0] coeff_reg = '0;
    logic signed [GAIN_W-1:0] gain_reg = GAIN_RESET;

    rsp_t pending_rsp [$];
    bit idle_on = 1'b1;
    int stall_run = 0;
    int mismatches = 0;
    int rsp_seen = 0;
    int settings = 0;
    int op_count [4] = '{default: 0};

    allpass_interpolated_delay_line uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("** allpass_interpolated_delay_line: FAILED **");
        $finish;
    end

    function automatic logic signed [SAMPLE_W-1:0] clamp(input longint v);
        if (v > SAT_HI)
            return SAMPLE_W'(SAT_HI);
        if (v < SAT_LO)
            return SAMPLE_W'(SAT_LO);
        return SAMPLE_W'(v);
    endfunction

    function automatic rsp_t line_step(input req_t w);
        rsp_t r;
        longint g;
        longint p;
        logic [ADDR_W-1:0] slot;
        r = '0;
        case (w.op)
            OP_SAMPLE:
            begin
                g = (longint'($signed(w.in_sample)) * longint'(gain_reg)
                     + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
                line_mem[wr_ptr] = clamp(g);
                slot = wr_ptr - lag_reg;
                p = (longint'(coeff_reg) * (longint'(line_mem[slot]) - longint'(last_out))
                     + (longint'(1) <<< (COEFF_FRAC - 1))) >>> COEFF_FRAC;
                r.out_sample = clamp(p + longint'(last_read));
                last_read = line_mem[slot];
                last_out = r.out_sample;
                wr_ptr = wr_ptr + 1'b1;
            end
            OP_TAP_READ:
            begin
                slot = wr_ptr - w.tap_age - 1'b1;
                r.tap_value = line_mem[slot];
            end
            OP_TAP_WRITE:
            begin
                slot = wr_ptr - w.tap_age - 1'b1;
                line_mem[slot] = w.in_sample;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic req_t word(input logic [OP_W-1:0] op, input longint s, input int age);
        req_t w;
        w.op = op;
        w.in_sample = SAMPLE_W'(s);
        w.tap_age = LAG_W'(age);
        return w;
    endfunction

    function automatic req_t random_word(input int sample_pct, input int age_span);
        req_t w;
        int pick;
        pick = $urandom_range(0, 99);
        w.in_sample = $signed(SAMPLE_W'($urandom)) >>> $urandom_range(0, 12);
        if ($urandom_range(0, 19) == 0)
            w.in_sample = $urandom_range(0, 1) ? SAMPLE_W'(SAT_HI) : SAMPLE_W'(SAT_LO);
        if ($urandom_range(0, 3) == 0)
            w.tap_age = LAG_W'($urandom);
        else
            w.tap_age = LAG_W'($urandom_range(0, age_span));
        if (pick < sample_pct)
            w.op = OP_SAMPLE;
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                w.op = OP_TAP_READ;
            else if (pick < 9)
                w.op = OP_TAP_WRITE;
            else
                w.op = OP_UNUSED;
        end
        return w;
    endfunction

    task automatic push_word(input req_t w);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 99) < 10)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req_word <= w;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        pending_rsp.push_back(line_step(w));
        op_count[w.op]++;
    endtask

    task automatic hold_req();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [LAG_W-1:0] lag, input logic signed [COEFF_W-1:0] coeff,
                              input logic signed [GAIN_W-1:0] gain);
        hold_req();
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_READ_LAG;
        cfg_data <= CFG_W'(lag);
        @(negedge clk);
        cfg_index <= CFG_ALLPASS_COEFF;
        cfg_data <= CFG_W'(coeff);
        @(negedge clk);
        cfg_index <= CFG_INPUT_GAIN;
        cfg_data <= CFG_W'(gain);
        @(negedge clk);
        cfg_we <= 1'b0;
        lag_reg = lag;
        coeff_reg = coeff;
        gain_reg = gain;
        settings++;
    endtask

    task automatic random_setting(input int phase);
        logic [LAG_W-1:0] lag;
        logic signed [GAIN_W-1:0] gain;
        if (phase % 3 == 2)
            lag = LAG_W'($urandom_range(64, 700));
        else
            lag = LAG_W'($urandom_range(0, 48));
        if ($urandom_range(0, 1))
            gain = GAIN_W'($urandom);
        else
            gain = GAIN_W'($urandom_range(0, 8192)) - GAIN_W'(4096);
        set_config(lag, COEFF_W'($urandom), gain);
    endtask

    // receiver: short random stalls with an occasional long run
    always @(negedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run--;
            rsp_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 299) == 0)
        begin
            stall_run = $urandom_range(6, 20);
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= idle_on && ($urandom_range(0, 99) < 9);
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_seen++;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result out_sample %0d tap_value %0d", $realtime,
                             rsp_word.out_sample, rsp_word.tap_value);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_word.out_sample !== want.out_sample
                    || rsp_word.tap_value !== want.tap_value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: out_sample exp %0d got %0d, tap_value exp %0d got %0d",
                                 $realtime, want.out_sample, rsp_word.out_sample,
                                 want.tap_value, rsp_word.tap_value);
                end
            end
        end
    end

    // reset values, store cleared, unused code while the clear is running
    task automatic test_reset_state();
        push_word(word(OP_UNUSED, -1, 4095));
        push_word(word(OP_TAP_READ, 0, 0));
        push_word(word(OP_TAP_READ, 0, 4095));
        push_word(word(OP_SAMPLE, SAT_HI, 0));
        push_word(word(OP_SAMPLE, SAT_LO, 4095));
        push_word(word(OP_SAMPLE, 1, 0));
        push_word(word(OP_TAP_READ, 0, 1));
    endtask

    // register extremes, saturation, tap wrap and half-way rounding
    task automatic test_extremes();
        set_config(LAG_W'(1), COEFF_W'(65535), GAIN_W'(-32768));
        push_word(word(OP_SAMPLE, SAT_LO, 0));
        push_word(word(OP_SAMPLE, SAT_HI, 0));
        push_word(word(OP_SAMPLE, 5, 0));
        push_word(word(OP_SAMPLE, -5, 0));
        set_config(LAG_W'(4095), COEFF_W'(-65536), GAIN_W'(32767));
        push_word(word(OP_SAMPLE, SAT_HI, 0));
        push_word(word(OP_SAMPLE, -1, 0));
        push_word(word(OP_TAP_WRITE, SAT_HI, 0));
        push_word(word(OP_TAP_WRITE, SAT_LO, 4095));
        push_word(word(OP_TAP_READ, 0, 0));
        push_word(word(OP_TAP_READ, 0, 4095));
        push_word(word(OP_TAP_READ, 0, 1));
        push_word(word(OP_UNUSED, 0, 0));
        set_config(LAG_W'(0), COEFF_W'(32768), GAIN_W'(2048));
        push_word(word(OP_SAMPLE, 3, 0));
        push_word(word(OP_SAMPLE, -3, 0));
        push_word(word(OP_SAMPLE, 1, 0));
        push_word(word(OP_SAMPLE, -1, 0));
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                set_config(LAG_W'(4095), COEFF_W'(-65536), GAIN_W'(-32768));
            else if (phase == 1)
                set_config(LAG_W'(0), COEFF_W'(65535), GAIN_W'(32767));
            else
                random_setting(phase);
            for (int n = 0; n < 120; n++)
                push_word(random_word(75, 64));
        end
    endtask

    // sender waits for every result before each burst
    task automatic test_drain_pauses();
        random_setting(0);
        for (int burst = 0; burst < 3; burst++)
        begin
            for (int n = 0; n < 40; n++)
                push_word(random_word(70, 32));
            hold_req();
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        random_setting(1);
        idle_on = 1'b0;
        for (int n = 0; n < 200; n++)
            push_word(random_word(80, 48));
        hold_req();
        wait_drained();
        idle_on = 1'b1;
    endtask

    initial
    begin
        foreach (line_mem[i])
            line_mem[i] = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_extremes();
        test_random_settings();
        test_drain_pauses();
        test_back_to_back();

        hold_req();
        wait_drained();
        repeat (16) @(posedge clk);
        $display("covered %0d samples, %0d tap reads, %0d tap writes, %0d unused codes",
                 op_count[OP_SAMPLE], op_count[OP_TAP_READ], op_count[OP_TAP_WRITE],
                 op_count[OP_UNUSED]);
        $display("across %0d register settings; %0d results checked, %0d mismatches",
                 settings, rsp_seen, mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("** allpass_interpolated_delay_line: PASSED **");
        else
            $display("** allpass_interpolated_delay_line: FAILED **");
        $finish;
    end

endmodule

[files.f]
src/adp_pkg.sv
src/adp_ram.sv
src/adp_mul.sv
src/adp_seq.sv
src/allpass_interpolated_delay_line.sv
src/adp_checker.sv
test/tb_allpass_interpolated_delay_line.sv
